// ===== rtl/core/rrss_pkg.sv =====
package rrss_pkg;

  // fixed field widths of the ports
  localparam int CMD_W      = 2;
  localparam int COUNT_W    = 4;
  localparam int TICKS_IN_W = 16;
  localparam int RUN_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THREAD_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_LENGTH = 1'b1;

  localparam logic [COUNT_W-1:0]    THREAD_COUNT_RST = 4'd1;
  localparam logic [CFG_DATA_W-1:0] SLICE_LENGTH_RST = 16'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_YIELD = 2'd1,
    CMD_SLEEP = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_WAITING = 2'd0,
    ST_RUNNING = 2'd1,
    ST_SLEEP   = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_AGE   = 7'b0000010,
    S_SAVE  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_START = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

endpackage

// ===== rtl/core/round_robin_sleep_scheduler_core.sv =====
// channel   | signals                                        | direction
// ----------+------------------------------------------------+----------
// command   | command_valid, command_ready, command,         | in
//           | sleep_ticks                                    |
// result    | result_valid, result_ready, switched,          | out
//           | running_thread                                 |
// config    | write_enable, write_index, write_data          | in
//
// n is the live thread count. a tick reads all n timers, then forces a pass when the
// slice runs out; yield and sleep run a pass once started and go straight to done
// before start; start needs no sweep. the single status/timer memory port, walked one
// entry per cycle, sets these timings.
// one word in flight: command_ready is high only while the sequencer is idle.
// the result register lets the next word in while a result waits; a finished word
// holds in the done state until the result register is free.
// rst is synchronous; thread status resets through per-entry valid bits, no clear pass.
module round_robin_sleep_scheduler_core #(
  parameter int MAX_THREADS = 8,
  parameter int TICK_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                command_valid,
  output logic                                command_ready,
  input  logic [rrss_pkg::CMD_W-1:0]          command,
  input  logic [rrss_pkg::TICKS_IN_W-1:0]     sleep_ticks,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                switched,
  output logic [rrss_pkg::RUN_W-1:0]          running_thread,
  input  logic                                write_enable,
  input  logic [rrss_pkg::CFG_IDX_W-1:0]      write_index,
  input  logic [rrss_pkg::CFG_DATA_W-1:0]     write_data
);
  import rrss_pkg::*;

  localparam int CW = $clog2(MAX_THREADS);       // thread index width
  localparam int NW = $clog2(MAX_THREADS + 1);   // thread count width

  // truncate or zero extend a 16 bit tick value to the timer width
  function automatic logic [TICK_WIDTH-1:0] to_tick(input logic [15:0] v);
    logic [TICK_WIDTH+15:0] w;
    w = (TICK_WIDTH + 16)'(v);
    return w[TICK_WIDTH-1:0];
  endfunction

  // round-robin successor, wrapping at the live count
  function automatic logic [CW-1:0] wrap_next(input logic [CW-1:0] a,
                                              input logic [NW-1:0] n);
    logic [NW-1:0] p;
    p = NW'(a) + NW'(1);
    return (p >= n) ? '0 : CW'(p);
  endfunction

  // configuration
  logic [COUNT_W-1:0]    thread_count;
  logic [CFG_DATA_W-1:0] slice_length;

  // scheduler state
  state_t                state;
  logic                  started;
  logic [CW-1:0]         current_thread;
  logic [TICK_WIDTH-1:0] slice_remaining;
  cmd_t                  cur_cmd;
  logic [TICK_WIDTH-1:0] cur_ticks;
  logic                  sw;

  // per-thread storage; timers are only read for sleepers, which always got one written
  status_t               status_mem [MAX_THREADS];
  logic [TICK_WIDTH-1:0] nap_mem    [MAX_THREADS];
  logic [MAX_THREADS-1:0] status_vld;

  // read sweep: address issue and registered read data
  logic                  issue_on;
  logic [CW-1:0]         rd_addr;
  logic [NW-1:0]         iss_cnt;
  logic                  rd_en;
  logic                  pv_q;
  logic                  last_q;
  logic [CW-1:0]         idx_q;
  status_t               status_q;
  logic                  vld_q;
  logic [TICK_WIDTH-1:0] nap_q;

  // write port controls
  logic                  st_we;
  logic [CW-1:0]         st_wa;
  status_t               st_wd;
  logic                  nap_we;
  logic [CW-1:0]         nap_wa;
  logic [TICK_WIDTH-1:0] nap_wd;

  // derived values
  logic [NW+3:0]         tc_wide;
  logic [NW-1:0]         live_n;
  logic [TICK_WIDTH-1:0] slice_cfg;
  logic [TICK_WIDTH-1:0] reload;
  status_t               eff_status;
  logic [TICK_WIDTH-1:0] nap_dec;
  logic                  scan_hit;
  logic                  start_ok;
  logic [CW+2:0]         cur_ext;

  always_comb begin
    // zero threads counts as one, more than the table holds is clamped
    tc_wide = (NW + 4)'(thread_count);
    if (tc_wide == '0) begin
      live_n = NW'(1);
    end else if (tc_wide > (NW + 4)'(MAX_THREADS)) begin
      live_n = NW'(MAX_THREADS);
    end else begin
      live_n = NW'(tc_wide);
    end
    slice_cfg = to_tick(slice_length);
    reload    = (slice_cfg == '0) ? TICK_WIDTH'(1) : slice_cfg;
    // entries never written read as their reset status
    if (vld_q) begin
      eff_status = status_q;
    end else begin
      eff_status = (idx_q == '0) ? ST_IDLE : ST_WAITING;
    end
    nap_dec  = (nap_q != '0) ? nap_q - TICK_WIDTH'(1) : '0;
    // eligible: not idle thread, not sleeping, not idle status
    scan_hit = (state == S_SCAN) && pv_q && (idx_q != '0) &&
               (eff_status != ST_SLEEP) && (eff_status != ST_IDLE);
    start_ok = !started && (live_n >= NW'(2));
    rd_en    = ((state == S_AGE) || (state == S_SCAN)) && issue_on && !scan_hit;
    cur_ext  = (CW + 3)'(current_thread);
  end

  // memory write selection
  always_comb begin
    st_we  = 1'b0;
    st_wa  = idx_q;
    st_wd  = ST_WAITING;
    nap_we = 1'b0;
    nap_wa = idx_q;
    nap_wd = nap_dec;
    unique case (state)
      S_AGE: begin
        // age a sleeper, wake it when the timer hits zero
        if (pv_q && (eff_status == ST_SLEEP)) begin
          nap_we = 1'b1;
          if (nap_dec == '0) begin
            st_we = 1'b1;
          end
        end
      end
      S_SAVE: begin
        // park the outgoing thread; a sleep command also loads its timer, except for the idle thread
        st_we = 1'b1;
        st_wa = current_thread;
        if (current_thread == '0) begin
          st_wd = ST_IDLE;
        end else if (cur_cmd == CMD_SLEEP) begin
          st_wd = ST_SLEEP;
        end else begin
          st_wd = ST_WAITING;
        end
        nap_we = (cur_cmd == CMD_SLEEP) && (current_thread != '0);
        nap_wa = current_thread;
        nap_wd = cur_ticks;
      end
      S_SCAN: begin
        if (scan_hit) begin
          st_we = 1'b1;
          st_wd = ST_RUNNING;
        end
      end
      S_START: begin
        if (start_ok) begin
          st_we = 1'b1;
          st_wa = CW'(1);
          st_wd = ST_RUNNING;
        end
      end
      default: begin
      end
    endcase
  end

  // status and timer memories, registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      status_mem[st_wa] <= st_wd;
    end
    if (nap_we) begin
      nap_mem[nap_wa] <= nap_wd;
    end
    if (rd_en) begin
      status_q <= status_mem[rd_addr];
      nap_q    <= nap_mem[rd_addr];
      vld_q    <= status_vld[rd_addr];
      idx_q    <= rd_addr;
      last_q   <= (iss_cnt == live_n - NW'(1));
    end
  end

  assign command_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      started         <= 1'b0;
      current_thread  <= '0;
      slice_remaining <= '0;
      thread_count    <= THREAD_COUNT_RST;
      slice_length    <= SLICE_LENGTH_RST;
      status_vld      <= '0;
      issue_on        <= 1'b0;
      pv_q            <= 1'b0;
      sw              <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (write_enable) begin
        unique case (write_index)
          REG_THREAD_COUNT: thread_count <= write_data[COUNT_W-1:0];
          REG_SLICE_LENGTH: slice_length <= write_data;
        endcase
      end

      // one read per cycle over the sweep, stop after n entries
      pv_q <= rd_en;
      if (rd_en) begin
        rd_addr <= wrap_next(rd_addr, live_n);
        iss_cnt <= iss_cnt + NW'(1);
        if (iss_cnt == live_n - NW'(1)) begin
          issue_on <= 1'b0;
        end
      end

      if (st_we) begin
        status_vld[st_wa] <= 1'b1;
      end

      // the done state reloads the register itself when it is taken
      if (result_valid && result_ready && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (command_valid) begin
            cur_cmd   <= cmd_t'(command);
            cur_ticks <= to_tick(sleep_ticks);
            sw        <= 1'b0;
            unique case (cmd_t'(command))
              CMD_TICK: begin
                rd_addr  <= '0;
                iss_cnt  <= '0;
                issue_on <= 1'b1;
                state    <= S_AGE;
              end
              CMD_YIELD, CMD_SLEEP: begin
                state <= started ? S_SAVE : S_DONE;
              end
              CMD_START: begin
                state <= S_START;
              end
            endcase
          end
        end
        S_AGE: begin
          // after the last timer, count down the slice once started; a used-up slice starts a pass
          if (pv_q && last_q) begin
            if (!started) begin
              state <= S_DONE;
            end else if (slice_remaining <= TICK_WIDTH'(1)) begin
              state <= S_SAVE;
            end else begin
              slice_remaining <= slice_remaining - TICK_WIDTH'(1);
              state           <= S_DONE;
            end
          end
        end
        S_SAVE: begin
          rd_addr  <= wrap_next(current_thread, live_n);
          iss_cnt  <= '0;
          issue_on <= 1'b1;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_hit) begin
            current_thread  <= idx_q;
            slice_remaining <= reload;
            sw              <= 1'b1;
            issue_on        <= 1'b0;
            state           <= S_DONE;
          end else if (pv_q && last_q) begin
            // full pass found nobody, fall back to idle
            current_thread  <= '0;
            slice_remaining <= reload;
            sw              <= 1'b1;
            state           <= S_DONE;
          end
        end
        S_START: begin
          if (start_ok) begin
            started         <= 1'b1;
            current_thread  <= CW'(1);
            slice_remaining <= reload;
            sw              <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid   <= 1'b1;
            switched       <= sw;
            running_thread <= cur_ext[2:0];
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // start is the only way in to the started state
  a_start_src: assert property (@(posedge clk) disable iff (rst)
    $rose(started) |-> $past(state == S_START))
    else $error("started rose outside the start step");

  // before start the idle thread is the one running
  a_idle_before_start: assert property (@(posedge clk) disable iff (rst)
    !started |-> (current_thread == '0))
    else $error("thread selected before start");

  // a word in flight blocks the next one
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (command_valid && command_ready) |=> !command_ready)
    else $error("second word taken while busy");

  // a sweep never reads more than the live thread count
  a_sweep_len: assert property (@(posedge clk) disable iff (rst)
    ((state == S_AGE) || (state == S_SCAN)) |-> (iss_cnt <= live_n))
    else $error("sweep ran past the thread count");

endmodule
